>>> rtl/i2cmra_pkg.sv
// Package with the shared types and constants of the I2C register-access master.
`timescale 1ns / 1ps

package i2cmra_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 7;
  localparam int unsigned CfgDataWidth = 7;
  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_CLOCK_STRETCH  = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    SLOT_ADDR_WR = 2'd0,
    SLOT_REG     = 2'd1,
    SLOT_THIRD   = 2'd2
  } slot_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_S_SDA_REL = 5'd1,
    PH_S_SCL_REL = 5'd2,
    PH_S_SDA_LOW = 5'd3,
    PH_S_SCL_LOW = 5'd4,
    PH_TX_SET    = 5'd5,
    PH_TX_HIGH   = 5'd6,
    PH_TX_LOW    = 5'd7,
    PH_ACK_REL   = 5'd8,
    PH_ACK_HIGH  = 5'd9,
    PH_ACK_LOW   = 5'd10,
    PH_RX_REL    = 5'd11,
    PH_RX_HIGH   = 5'd12,
    PH_RX_LOW    = 5'd13,
    PH_NACK_SET  = 5'd14,
    PH_NACK_HIGH = 5'd15,
    PH_NACK_LOW  = 5'd16,
    PH_P_SCL_LOW = 5'd17,
    PH_P_SDA_LOW = 5'd18,
    PH_P_SCL_HI  = 5'd19,
    PH_P_SDA_HI  = 5'd20
  } phase_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [ByteWidth-1:0] reg_addr;
    logic [ByteWidth-1:0] write_data;
    logic                 sda_in;
    logic                 scl_in;
  } req_t;

  typedef struct packed {
    logic                 scl_low;
    logic                 sda_low;
    logic                 busy_res;
    logic                 done_res;
    logic [ByteWidth-1:0] read_data;
    logic                 ack_ok;
  } res_t;

endpackage

>>> rtl/i2cmra_if.sv
// Request and result channel interfaces of the I2C register-access master.
`timescale 1ns / 1ps

interface i2cmra_req_if;
  import i2cmra_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [ByteWidth-1:0] reg_addr;
  logic [ByteWidth-1:0] write_data;
  logic                 sda_in;
  logic                 scl_in;

  modport source (output valid, op, reg_addr, write_data, sda_in, scl_in, input ready);
  modport sink (input valid, op, reg_addr, write_data, sda_in, scl_in, output ready);
endinterface

interface i2cmra_res_if;
  import i2cmra_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 scl_low;
  logic                 sda_low;
  logic                 busy_res;
  logic                 done_res;
  logic [ByteWidth-1:0] read_data;
  logic                 ack_ok;

  modport source (output valid, scl_low, sda_low, busy_res, done_res, read_data, ack_ok,
                  input ready);
  modport sink (input valid, scl_low, sda_low, busy_res, done_res, read_data, ack_ok,
                output ready);
endinterface

>>> rtl/i2c_master_register_access.sv
// Top level of the open-drain I2C master for single register reads and writes.
//
//   channel  direction  payload
//   req_i    in         op, reg_addr, write_data, sda_in, scl_in
//   res_o    out        scl_low, sda_low, busy_res, done_res, read_data, ack_ok
//   cfg      in         cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// Every request advances the bus by one pin step in the cycle it is accepted;
// its result is registered in the result buffer before it shows on res_o.
// The step logic over the state registers takes one request per cycle while
// the result buffer has room. A two-entry result buffer keeps requests flowing
// while res_o is stalled; ready drops only once both entries hold results.
// Reset clears the state to idle with both lines released, and needs no sweep.
`timescale 1ns / 1ps

module i2c_master_register_access
  import i2cmra_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  i2cmra_req_if.sink              req_i,
  i2cmra_res_if.source            res_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic [AddrWidth-1:0] device_address_q;
  logic                 stretch_en_q;
  logic                 step;
  logic                 buf_ready;
  req_t                 req;
  res_t                 step_res;
  res_t                 out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= '0;
      stretch_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS: device_address_q <= cfg_data_i[AddrWidth-1:0];
        CFG_CLOCK_STRETCH:  stretch_en_q     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign req_i.ready = buf_ready;
  assign step        = req_i.valid && buf_ready;

  always_comb begin
    req.op         = req_i.op;
    req.reg_addr   = req_i.reg_addr;
    req.write_data = req_i.write_data;
    req.sda_in     = req_i.sda_in;
    req.scl_in     = req_i.scl_in;
  end

  i2cmra_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .req_i            (req),
    .device_address_i (device_address_q),
    .stretch_en_i     (stretch_en_q),
    .res_o            (step_res)
  );

  i2cmra_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (step),
    .push_data_i  (step_res),
    .push_ready_o (buf_ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .out_data_o   (out_res)
  );

  assign res_o.scl_low   = out_res.scl_low;
  assign res_o.sda_low   = out_res.sda_low;
  assign res_o.busy_res  = out_res.busy_res;
  assign res_o.done_res  = out_res.done_res;
  assign res_o.read_data = out_res.read_data;
  assign res_o.ack_ok    = out_res.ack_ok;

  // The stop step always ends the transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res)
    else $error("done reported while still busy");

  // Outside a transaction both lines are released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.busy_res |-> !res_o.scl_low && !res_o.sda_low)
    else $error("line driven low while idle");

  // Requests are held off only when the result buffer is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> res_o.valid)
    else $error("request stalled with no pending result");

  // A request accepted into an empty buffer shows its result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && !res_o.valid |=> res_o.valid)
    else $error("accepted request produced no result");

endmodule

>>> rtl/i2cmra_core.sv
// Bus sequencer: transaction state registers and the one-step pin logic.
`timescale 1ns / 1ps

module i2cmra_core
  import i2cmra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  req_t                 req_i,
  input  logic [AddrWidth-1:0] device_address_i,
  input  logic                 stretch_en_i,
  output res_t                 res_o
);

  phase_e               phase_q, phase_d;
  logic [3:0]           bit_index_q, bit_index_d;
  logic [ByteWidth-1:0] shift_byte_q, shift_byte_d;
  logic [ByteWidth-1:0] received_q, received_d;
  logic                 ack_all_q, ack_all_d;
  logic                 is_read_q, is_read_d;
  logic [ByteWidth-1:0] held_reg_q, held_reg_d;
  logic [ByteWidth-1:0] held_data_q, held_data_d;
  logic                 clock_drive_q, clock_drive_d;
  logic                 data_drive_q, data_drive_d;
  slot_e                slot_q, slot_d;

  logic       stalled;
  logic [3:0] bit_index_inc;

  assign stalled       = stretch_en_i && !req_i.scl_in;
  assign bit_index_inc = bit_index_q + 4'd1;

  // Next state for one pin step.
  always_comb begin
    phase_d       = phase_q;
    bit_index_d   = bit_index_q;
    shift_byte_d  = shift_byte_q;
    received_d    = received_q;
    ack_all_d     = ack_all_q;
    is_read_d     = is_read_q;
    held_reg_d    = held_reg_q;
    held_data_d   = held_data_q;
    clock_drive_d = clock_drive_q;
    data_drive_d  = data_drive_q;
    slot_d        = slot_q;
    case (phase_q)
      PH_IDLE: begin
        // A request performs its first pin step, the SDA release, at once.
        if (req_i.op == OP_READ || req_i.op == OP_WRITE) begin
          is_read_d   = (req_i.op == OP_READ);
          held_reg_d  = req_i.reg_addr;
          held_data_d = req_i.write_data;
          if (req_i.op == OP_WRITE) begin
            ack_all_d = 1'b1;
          end
          slot_d       = SLOT_ADDR_WR;
          data_drive_d = 1'b0;
          phase_d      = PH_S_SCL_REL;
        end
      end
      PH_S_SDA_REL: begin
        data_drive_d = 1'b0;
        phase_d      = PH_S_SCL_REL;
      end
      PH_S_SCL_REL: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_S_SDA_LOW;
      end
      PH_S_SDA_LOW: begin
        data_drive_d = 1'b1;
        phase_d      = PH_S_SCL_LOW;
      end
      PH_S_SCL_LOW: begin
        clock_drive_d = 1'b1;
        shift_byte_d  = {device_address_i, slot_q == SLOT_THIRD};
        bit_index_d   = 4'd0;
        phase_d       = PH_TX_SET;
      end
      PH_TX_SET: begin
        data_drive_d = !shift_byte_q[ByteWidth-1];
        phase_d      = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        if (!stalled) begin
          clock_drive_d = 1'b1;
          shift_byte_d  = {shift_byte_q[ByteWidth-2:0], 1'b0};
          bit_index_d   = bit_index_inc;
          phase_d       = (bit_index_inc >= BitsPerByte) ? PH_ACK_REL : PH_TX_SET;
        end
      end
      PH_ACK_REL: begin
        data_drive_d = 1'b0;
        phase_d      = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_ACK_LOW;
      end
      PH_ACK_LOW: begin
        if (!stalled) begin
          // During a write, a high SDA at the sample is a missing acknowledge.
          if (!is_read_q && req_i.sda_in) begin
            ack_all_d = 1'b0;
          end
          clock_drive_d = 1'b1;
          case (slot_q)
            SLOT_ADDR_WR: begin
              slot_d       = SLOT_REG;
              shift_byte_d = held_reg_q;
              bit_index_d  = 4'd0;
              phase_d      = PH_TX_SET;
            end
            SLOT_REG: begin
              slot_d = SLOT_THIRD;
              if (is_read_q) begin
                phase_d = PH_S_SDA_REL;
              end else begin
                shift_byte_d = held_data_q;
                bit_index_d  = 4'd0;
                phase_d      = PH_TX_SET;
              end
            end
            default: begin
              phase_d = is_read_q ? PH_RX_REL : PH_P_SCL_LOW;
            end
          endcase
        end
      end
      PH_RX_REL: begin
        data_drive_d = 1'b0;
        shift_byte_d = '0;
        bit_index_d  = 4'd0;
        phase_d      = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_RX_LOW;
      end
      PH_RX_LOW: begin
        if (!stalled) begin
          shift_byte_d  = {shift_byte_q[ByteWidth-2:0], req_i.sda_in};
          clock_drive_d = 1'b1;
          bit_index_d   = bit_index_inc;
          phase_d       = (bit_index_inc >= BitsPerByte) ? PH_NACK_SET : PH_RX_HIGH;
        end
      end
      PH_NACK_SET: begin
        received_d   = shift_byte_q;
        data_drive_d = 1'b0;
        phase_d      = PH_NACK_HIGH;
      end
      PH_NACK_HIGH: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_NACK_LOW;
      end
      PH_NACK_LOW: begin
        if (!stalled) begin
          clock_drive_d = 1'b1;
          phase_d       = PH_P_SCL_LOW;
        end
      end
      PH_P_SCL_LOW: begin
        clock_drive_d = 1'b1;
        phase_d       = PH_P_SDA_LOW;
      end
      PH_P_SDA_LOW: begin
        data_drive_d = 1'b1;
        phase_d      = PH_P_SCL_HI;
      end
      PH_P_SCL_HI: begin
        clock_drive_d = 1'b0;
        phase_d       = PH_P_SDA_HI;
      end
      PH_P_SDA_HI: begin
        if (!stalled) begin
          data_drive_d = 1'b0;
          phase_d      = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Result of the step, taken from the state after it.
  always_comb begin
    res_o.scl_low   = clock_drive_d;
    res_o.sda_low   = data_drive_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = (phase_q == PH_P_SDA_HI) && !stalled;
    res_o.read_data = received_d;
    res_o.ack_ok    = ack_all_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_index_q   <= '0;
      shift_byte_q  <= '0;
      received_q    <= '0;
      ack_all_q     <= 1'b1;
      is_read_q     <= 1'b0;
      held_reg_q    <= '0;
      held_data_q   <= '0;
      clock_drive_q <= 1'b0;
      data_drive_q  <= 1'b0;
      slot_q        <= SLOT_ADDR_WR;
    end else if (step_i) begin
      phase_q       <= phase_d;
      bit_index_q   <= bit_index_d;
      shift_byte_q  <= shift_byte_d;
      received_q    <= received_d;
      ack_all_q     <= ack_all_d;
      is_read_q     <= is_read_d;
      held_reg_q    <= held_reg_d;
      held_data_q   <= held_data_d;
      clock_drive_q <= clock_drive_d;
      data_drive_q  <= data_drive_d;
      slot_q        <= slot_d;
    end
  end

endmodule

>>> rtl/i2cmra_out_buf.sv
// Two-entry result buffer: an output register and a skid register behind it.
`timescale 1ns / 1ps

module i2cmra_out_buf
  import i2cmra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic push_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q, out_data_d;
  res_t skid_data_q, skid_data_d;
  logic pop;

  assign pop          = out_valid_q && out_ready_i;
  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the I2C register-access master, with a built-in bus predictor.
`timescale 1ns / 1ps

module tb
  import i2cmra_pkg::*;
;

  // The op field is two bits wide, and its fourth code is treated as a tick.
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned HoldOffCycles = 64;

  class i2c_bus_scoreboard;
    logic [AddrWidth-1:0] dev_addr;
    logic                 stretch_en;
    phase_e               phase;
    slot_e                slot;
    logic [3:0]           bit_cnt;
    logic [ByteWidth-1:0] shift_q;
    logic [ByteWidth-1:0] rx_byte;
    logic [ByteWidth-1:0] reg_q;
    logic [ByteWidth-1:0] data_q;
    logic                 ack_all;
    logic                 is_read;
    logic                 scl_drive;
    logic                 sda_drive;
    res_t                 expected_steps[$];
    int unsigned          mismatch_count;

    function new();
      dev_addr = '0;
      stretch_en = 1'b0;
      phase = PH_IDLE;
      slot = SLOT_ADDR_WR;
      bit_cnt = '0;
      shift_q = '0;
      rx_byte = '0;
      reg_q = '0;
      data_q = '0;
      ack_all = 1'b1;
      is_read = 1'b0;
      scl_drive = 1'b0;
      sda_drive = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_index_e idx, logic [CfgDataWidth-1:0] value);
      if (idx == CFG_DEVICE_ADDRESS) begin
        dev_addr = value[AddrWidth-1:0];
      end else begin
        stretch_en = value[0];
      end
    endfunction

    function bit bus_idle();
      return phase == PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_steps.size();
    endfunction

    // Advances the bus by one pin step and returns the pin and status levels after it.
    function res_t predict_step(req_t r);
      logic stalled;
      logic done;
      res_t step;
      stalled = stretch_en && !r.scl_in;
      done = 1'b0;
      if (phase == PH_IDLE) begin
        if (r.op == OP_READ || r.op == OP_WRITE) begin
          is_read = (r.op == OP_READ);
          reg_q = r.reg_addr;
          data_q = r.write_data;
          if (!is_read) begin
            ack_all = 1'b1;
          end
          slot = SLOT_ADDR_WR;
          sda_drive = 1'b0;
          phase = PH_S_SCL_REL;
        end
      end else begin
        case (phase)
          PH_S_SDA_REL: begin
            sda_drive = 1'b0;
            phase = PH_S_SCL_REL;
          end
          PH_S_SCL_REL: begin
            scl_drive = 1'b0;
            phase = PH_S_SDA_LOW;
          end
          PH_S_SDA_LOW: begin
            sda_drive = 1'b1;
            phase = PH_S_SCL_LOW;
          end
          PH_S_SCL_LOW: begin
            scl_drive = 1'b1;
            shift_q = {dev_addr, slot == SLOT_THIRD};
            bit_cnt = '0;
            phase = PH_TX_SET;
          end
          PH_TX_SET: begin
            sda_drive = !shift_q[ByteWidth-1];
            phase = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            scl_drive = 1'b0;
            phase = PH_TX_LOW;
          end
          PH_TX_LOW: begin
            if (!stalled) begin
              scl_drive = 1'b1;
              shift_q = {shift_q[ByteWidth-2:0], 1'b0};
              bit_cnt = bit_cnt + 4'd1;
              phase = (bit_cnt >= BitsPerByte) ? PH_ACK_REL : PH_TX_SET;
            end
          end
          PH_ACK_REL: begin
            sda_drive = 1'b0;
            phase = PH_ACK_HIGH;
          end
          PH_ACK_HIGH: begin
            scl_drive = 1'b0;
            phase = PH_ACK_LOW;
          end
          PH_ACK_LOW: begin
            if (!stalled) begin
              if (!is_read && r.sda_in) begin
                ack_all = 1'b0;
              end
              scl_drive = 1'b1;
              if (slot == SLOT_ADDR_WR) begin
                slot = SLOT_REG;
                shift_q = reg_q;
                bit_cnt = '0;
                phase = PH_TX_SET;
              end else if (slot == SLOT_REG) begin
                slot = SLOT_THIRD;
                if (is_read) begin
                  // A read turns around with a repeated start before the read address.
                  phase = PH_S_SDA_REL;
                end else begin
                  shift_q = data_q;
                  bit_cnt = '0;
                  phase = PH_TX_SET;
                end
              end else begin
                phase = is_read ? PH_RX_REL : PH_P_SCL_LOW;
              end
            end
          end
          PH_RX_REL: begin
            sda_drive = 1'b0;
            shift_q = '0;
            bit_cnt = '0;
            phase = PH_RX_HIGH;
          end
          PH_RX_HIGH: begin
            scl_drive = 1'b0;
            phase = PH_RX_LOW;
          end
          PH_RX_LOW: begin
            if (!stalled) begin
              shift_q = {shift_q[ByteWidth-2:0], r.sda_in};
              scl_drive = 1'b1;
              bit_cnt = bit_cnt + 4'd1;
              phase = (bit_cnt >= BitsPerByte) ? PH_NACK_SET : PH_RX_HIGH;
            end
          end
          PH_NACK_SET: begin
            rx_byte = shift_q;
            sda_drive = 1'b0;
            phase = PH_NACK_HIGH;
          end
          PH_NACK_HIGH: begin
            scl_drive = 1'b0;
            phase = PH_NACK_LOW;
          end
          PH_NACK_LOW: begin
            if (!stalled) begin
              scl_drive = 1'b1;
              phase = PH_P_SCL_LOW;
            end
          end
          PH_P_SCL_LOW: begin
            scl_drive = 1'b1;
            phase = PH_P_SDA_LOW;
          end
          PH_P_SDA_LOW: begin
            sda_drive = 1'b1;
            phase = PH_P_SCL_HI;
          end
          PH_P_SCL_HI: begin
            scl_drive = 1'b0;
            phase = PH_P_SDA_HI;
          end
          PH_P_SDA_HI: begin
            if (!stalled) begin
              sda_drive = 1'b0;
              done = 1'b1;
              phase = PH_IDLE;
            end
          end
          default: begin
            phase = PH_IDLE;
          end
        endcase
      end
      step.scl_low = scl_drive;
      step.sda_low = sda_drive;
      step.busy_res = (phase != PH_IDLE);
      step.done_res = done;
      step.read_data = rx_byte;
      step.ack_ok = ack_all;
      return step;
    endfunction

    function void note_request(req_t r);
      expected_steps.push_back(predict_step(r));
    endfunction

    function string show(res_t s);
      return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b data=%02h ack=%0b",
                       s.scl_low, s.sda_low, s.busy_res, s.done_res, s.read_data, s.ack_ok);
    endfunction

    function void check_step(res_t got);
      res_t want;
      bit bad;
      if (expected_steps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no request outstanding: %s", $realtime, show(got));
        end
        return;
      end
      want = expected_steps.pop_front();
      bad = (got.scl_low !== want.scl_low) || (got.sda_low !== want.sda_low) ||
            (got.busy_res !== want.busy_res) || (got.done_res !== want.done_res) ||
            (got.read_data !== want.read_data) || (got.ack_ok !== want.ack_ok);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch, expected %s", $realtime, show(want));
          $display("%0t:           actual   %s", $realtime, show(got));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cfg_index_e cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  i2cmra_req_if req_if ();
  i2cmra_res_if res_if ();

  i2c_master_register_access uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  i2c_bus_scoreboard sb = new();

  int unsigned gap_pct;
  int unsigned stall_pct;
  bit hold_pending;
  int unsigned hold_left;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_pending) begin
      hold_left = HoldOffCycles;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.scl_low = res_if.scl_low;
      got.sda_low = res_if.sda_low;
      got.busy_res = res_if.busy_res;
      got.done_res = res_if.done_res;
      got.read_data = res_if.read_data;
      got.ack_ok = res_if.ack_ok;
      sb.check_step(got);
    end
  end

  task automatic send_request(req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= r.op;
    req_if.reg_addr <= r.reg_addr;
    req_if.write_data <= r.write_data;
    req_if.sda_in <= r.sda_in;
    req_if.scl_in <= r.scl_in;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_request(r);
  endtask

  function automatic req_t random_fields(logic [1:0] op);
    req_t r;
    r.op = op;
    r.reg_addr = 8'($urandom_range(255));
    r.write_data = 8'($urandom_range(255));
    r.sda_in = 1'($urandom_range(1));
    r.scl_in = 1'($urandom_range(1));
    return r;
  endfunction

  // A tick as a target would answer it: mostly acknowledges, and a held clock now and then.
  function automatic req_t bus_tick();
    req_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      r = random_fields(OP_READ);
    end else if (roll < 6) begin
      r = random_fields(OP_WRITE);
    end else if (roll < 9) begin
      r = random_fields(OpUnused);
    end else begin
      r = random_fields(OP_TICK);
    end
    if (sb.phase == PH_ACK_LOW) begin
      r.sda_in = ($urandom_range(99) < 12);
    end
    r.scl_in = ($urandom_range(99) >= 20);
    return r;
  endfunction

  task automatic finish_transaction();
    while (!sb.bus_idle()) begin
      send_request(bus_tick());
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(cfg_index_e idx, logic [CfgDataWidth-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic(int unsigned quota);
    int unsigned count;
    int unsigned burst;
    logic [1:0] op;
    count = 0;
    while (count < quota) begin
      if ($urandom_range(99) < 85) begin
        op = $urandom_range(1) ? OP_READ : OP_WRITE;
        send_request(random_fields(op));
        count++;
        while (!sb.bus_idle()) begin
          send_request(bus_tick());
          count++;
        end
      end else begin
        burst = $urandom_range(3, 1);
        repeat (burst) begin
          send_request(random_fields($urandom_range(1) ? OpUnused : OP_TICK));
        end
      end
    end
  endtask

  task automatic send_fields(logic [1:0] op, logic [7:0] reg_addr, logic [7:0] data,
                             logic sda, logic scl);
    req_t r;
    r.op = op;
    r.reg_addr = reg_addr;
    r.write_data = data;
    r.sda_in = sda;
    r.scl_in = scl;
    send_request(r);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DEVICE_ADDRESS;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_TICK;
    req_if.reg_addr = '0;
    req_if.write_data = '0;
    req_if.sda_in = 1'b1;
    req_if.scl_in = 1'b1;
    res_if.ready = 1'b0;
    hold_pending = 1'b0;
    hold_left = 0;
    gap_pct = 29;
    stall_pct = 76;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset configuration: idle ticks, the unused code,
    // requests while busy, a write finished with random target ticks, then a read.
    send_fields(OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
    send_fields(OP_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_fields(OpUnused, 8'hA5, 8'h5A, 1'b1, 1'b0);
    send_fields(OP_WRITE, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_fields(OP_READ, 8'h00, 8'hFF, 1'b0, 1'b1);
    send_fields(OpUnused, 8'hFF, 8'hFF, 1'b1, 1'b1);
    repeat (16) send_fields(OP_TICK, 8'h00, 8'h00, 1'b1, 1'b0);
    finish_transaction();
    send_fields(OP_READ, 8'h00, 8'hFF, 1'b1, 1'b1);
    finish_transaction();
    drain();

    write_register(CFG_DEVICE_ADDRESS, 7'h7F);
    write_register(CFG_CLOCK_STRETCH, 7'h01);
    hold_pending = 1'b1;
    run_traffic(100);
    drain();

    gap_pct = 76;
    stall_pct = 29;
    write_register(CFG_DEVICE_ADDRESS, 7'($urandom_range(126, 1)));
    write_register(CFG_CLOCK_STRETCH, 7'h00);
    hold_pending = 1'b1;
    run_traffic(100);
    drain();

    gap_pct = 0;
    stall_pct = 0;
    write_register(CFG_DEVICE_ADDRESS, 7'h00);
    write_register(CFG_CLOCK_STRETCH, 7'h01);
    hold_pending = 1'b1;
    run_traffic(100);
    drain();

    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> i2c_master_register_access.f
rtl/i2cmra_pkg.sv
rtl/i2cmra_if.sv
rtl/i2cmra_core.sv
rtl/i2cmra_out_buf.sv
rtl/i2c_master_register_access.sv
tb/tb.sv
